FILE: hw/rtl/lfdc_pkg.sv
// ----------------------------------------------------------------------------
// lfdc_pkg
// Shared widths, action and register codes, reset values and the line
// weight table for the line-follow drive controller.
// ----------------------------------------------------------------------------
package lfdc_pkg;

   localparam int SPEED_W   = 14;
   localparam int GAIN_W    = 10;
   localparam int TICK_W    = 8;
   localparam int FRONT_W   = 11;
   localparam int ACT_W     = 3;
   localparam int IDX_W     = 4;
   localparam int WMAG_W    = 10;
   localparam int OUT_SPD_W = 21;
   localparam int CALC_W    = 22;
   localparam int REQ_DW    = 16;
   localparam int RSP_DW    = 56;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 14;

   localparam logic [ACT_W-1:0] ACT_STOP     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_AHEAD    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_LEFT     = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RIGHT    = 3'd3;
   localparam logic [ACT_W-1:0] ACT_BACK     = 3'd4;
   localparam logic [ACT_W-1:0] ACT_APPROACH = 3'd5;

   localparam logic [CSR_AW-1:0] CSR_CRUISE_SPEED     = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_CRUISE_MIN_SPEED = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_CRUISE_GAIN      = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_APPROACH_SPEED   = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_APPROACH_GAIN    = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_FAST_TURN_SPEED  = 3'd5;
   localparam logic [CSR_AW-1:0] CSR_SLOW_TURN_SPEED  = 3'd6;
   localparam logic [CSR_AW-1:0] CSR_FAST_TURN_TICKS  = 3'd7;

   localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED     = 14'd8000;
   localparam logic [SPEED_W-1:0] RST_CRUISE_MIN_SPEED = 14'd100;
   localparam logic [GAIN_W-1:0]  RST_CRUISE_GAIN      = 10'd80;
   localparam logic [SPEED_W-1:0] RST_APPROACH_SPEED   = 14'd3000;
   localparam logic [GAIN_W-1:0]  RST_APPROACH_GAIN    = 10'd300;
   localparam logic [SPEED_W-1:0] RST_FAST_TURN_SPEED  = 14'd9000;
   localparam logic [SPEED_W-1:0] RST_SLOW_TURN_SPEED  = 14'd5000;
   localparam logic [TICK_W-1:0]  RST_FAST_TURN_TICKS  = 8'd10;

   localparam logic [IDX_W-1:0] RST_EDGE_LEFT  = 4'd0;
   localparam logic [IDX_W-1:0] RST_EDGE_RIGHT = 4'd11;
   localparam logic [IDX_W-1:0] POS_CENTRE     = 4'd5;
   localparam logic [IDX_W-1:0] POS_MAX        = 4'd10;

   localparam logic [TICK_W-1:0] AHEAD_TICKS_MAX  = 8'd255;
   localparam logic [TICK_W-1:0] CROSS_MIN_TICKS  = 8'd5;
   localparam logic [TICK_W-1:0] EARLY_MAX_TICKS  = 8'd10;
   localparam logic [3:0]        CROSS_MIN_COUNT  = 4'd7;

   // magnitude of the steering weight; positions below centre are negative
   function automatic logic [WMAG_W-1:0] weight_mag(input logic [IDX_W-1:0] pos);
      logic [WMAG_W-1:0] m;
      case (pos)
         4'd0, 4'd10: m = 10'd1000;
         4'd1, 4'd9:  m = 10'd300;
         4'd2:        m = 10'd150;
         4'd3, 4'd7:  m = 10'd60;
         4'd4, 4'd6:  m = 10'd50;
         4'd8:        m = 10'd100;
         default:     m = 10'd0;
      endcase
      return m;
   endfunction

endpackage

FILE: hw/rtl/line_follow_drive_controller.sv
// ----------------------------------------------------------------------------
// line_follow_drive_controller
// Action sequencer and differential steering for a line-following car.
// ----------------------------------------------------------------------------
// One result per request, one request per clock while rsp is not stalled. A
// request is registered, evaluated in a single pass against the action state
// and written to the result register. rsp_tvalid comes from the result register,
// so a request passes through the input and result registers before its rsp transfer.
// The state update (edge search, weight lookup and one 10x10 multiply) is
// combinational; back-pressure on rsp stalls the input register.
module line_follow_drive_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // front_sensors[10:0], left_side_sensor, right_side_sensor, action_code[2:0]
   input  logic [lfdc_pkg::REQ_DW-1:0]     req_tdata,
   // req_type
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // left_speed[20:0], right_speed[20:0], head_cross_event, on_cross_event,
   // finish_event, reverse_direction, command_accepted, action_now[2:0], pad
   output logic [lfdc_pkg::RSP_DW-1:0]     rsp_tdata,
   // drive_valid
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [lfdc_pkg::CSR_AW-1:0]     csr_addr,
   input  logic [lfdc_pkg::CSR_DW-1:0]     csr_wdata
);

   localparam int SW = lfdc_pkg::SPEED_W;
   localparam int GW = lfdc_pkg::GAIN_W;
   localparam int TW = lfdc_pkg::TICK_W;
   localparam int AW = lfdc_pkg::ACT_W;
   localparam int IW = lfdc_pkg::IDX_W;
   localparam int CW = lfdc_pkg::CALC_W;
   localparam int OW = lfdc_pkg::OUT_SPD_W;
   localparam int FW = lfdc_pkg::FRONT_W;

   // configuration
   logic [SW-1:0] cruise_speed_ff, cruise_min_speed_ff, approach_speed_ff;
   logic [SW-1:0] fast_turn_speed_ff, slow_turn_speed_ff;
   logic [GW-1:0] cruise_gain_ff, approach_gain_ff;
   logic [TW-1:0] fast_turn_ticks_ff;

   // input register
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_type_ff;
   logic [FW-1:0] s1_front_ff;
   logic          s1_side_ff;
   logic [AW-1:0] s1_code_ff;

   // action state
   logic [AW-1:0] action_ff, action_in;
   logic          intr_ff, intr_in;
   logic [TW-1:0] ahead_ticks_ff, ahead_ticks_in;
   logic [TW-1:0] lturn_ff, lturn_in;
   logic [TW-1:0] rturn_ff, rturn_in;
   logic [IW-1:0] edge_l_ff, edge_l_in;
   logic [IW-1:0] edge_r_ff, edge_r_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_user_ff, rsp_user_in;
   logic [lfdc_pkg::RSP_DW-1:0] rsp_data_ff, rsp_data_in;

   logic advance, fire, tick;

   // edge search and weight
   logic [IW-1:0]          edge_l_new, edge_r_new;
   logic signed [IW:0]     diff;
   logic signed [IW:0]     half;
   logic signed [IW+1:0]   pos_s;
   logic [IW-1:0]          pos;
   logic [lfdc_pkg::WMAG_W-1:0] wmag;
   logic                   wneg;
   logic [3:0]             count;
   logic                   front_cross;

   // steering arithmetic
   logic [SW-1:0]                     base_speed;
   logic [GW-1:0]                     gain;
   logic [lfdc_pkg::WMAG_W+GW-1:0]    prod;
   logic signed [CW-1:0]              slowed;
   logic signed [CW-1:0]              slowed_clamped;
   logic                              is_left_turn;
   logic [TW-1:0]                     turn_ticks;
   logic signed [CW-1:0]              turn_mag;

   // result fields
   logic signed [CW-1:0] left_spd, right_spd;
   logic hc, oc, fin, rev, acc;

   assign advance     = !rsp_valid_ff || rsp_tready;
   assign fire        = s1_valid_ff && advance;
   assign tick        = fire && !s1_type_ff;
   assign req_tready  = !s1_valid_ff || advance;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !advance);

   always_comb begin
      edge_l_new = edge_l_ff;
      edge_r_new = edge_r_ff;
      count      = '0;
      for (int i = 1; i < FW - 1; i++) begin
         if (s1_front_ff[i] && !s1_front_ff[i-1]) begin
            edge_l_new = IW'(i);
         end
         if (s1_front_ff[i] && !s1_front_ff[i+1]) begin
            edge_r_new = IW'(i);
         end
      end
      for (int i = 0; i < FW; i++) begin
         count = count + 4'(s1_front_ff[i]);
      end
   end

   // midpoint with truncation towards zero, clamped to the bar
   assign diff  = $signed({1'b0, edge_r_new}) - $signed({1'b0, edge_l_new});
   assign half  = (diff + $signed({{IW{1'b0}}, diff[IW]})) >>> 1;
   assign pos_s = (IW+2)'(half) + $signed({2'b00, edge_l_new});
   always_comb begin
      if (pos_s[IW+1]) begin
         pos = '0;
      end else if (pos_s > $signed({2'b00, lfdc_pkg::POS_MAX})) begin
         pos = lfdc_pkg::POS_MAX;
      end else begin
         pos = pos_s[IW-1:0];
      end
   end
   assign wmag = lfdc_pkg::weight_mag(pos);
   assign wneg = pos < lfdc_pkg::POS_CENTRE;

   assign front_cross = (count >= lfdc_pkg::CROSS_MIN_COUNT && (&s1_front_ff[2:0]))
                        || (&s1_front_ff[10:8]);

   assign base_speed = (action_ff == lfdc_pkg::ACT_APPROACH) ? approach_speed_ff
                                                             : cruise_speed_ff;
   assign gain       = (action_ff == lfdc_pkg::ACT_APPROACH) ? approach_gain_ff
                                                             : cruise_gain_ff;
   assign prod       = wmag * gain;
   assign slowed     = $signed(CW'(base_speed)) - $signed(CW'(prod));
   assign slowed_clamped = (slowed < $signed(CW'(cruise_min_speed_ff)))
                           ? $signed(CW'(cruise_min_speed_ff)) : slowed;

   assign is_left_turn = action_ff == lfdc_pkg::ACT_LEFT;
   assign turn_ticks   = is_left_turn ? lturn_ff : rturn_ff;

   always_comb begin
      logic [TW-1:0] at;
      at             = ahead_ticks_ff;
      action_in      = action_ff;
      intr_in        = intr_ff;
      ahead_ticks_in = ahead_ticks_ff;
      lturn_in       = lturn_ff;
      rturn_in       = rturn_ff;
      edge_l_in      = edge_l_ff;
      edge_r_in      = edge_r_ff;
      left_spd       = '0;
      right_spd      = '0;
      turn_mag       = '0;
      hc             = 1'b0;
      oc             = 1'b0;
      fin            = 1'b0;
      rev            = 1'b0;
      acc            = 1'b0;
      if (fire && s1_type_ff) begin
         if (intr_ff) begin
            action_in = s1_code_ff;
            acc       = 1'b1;
         end
      end else if (tick) begin
         case (action_ff)
            lfdc_pkg::ACT_AHEAD: begin
               if (at != lfdc_pkg::AHEAD_TICKS_MAX) begin
                  at = at + TW'(1);
               end
               intr_in = 1'b1;
               if (front_cross && at > lfdc_pkg::CROSS_MIN_TICKS) begin
                  hc = 1'b1;
                  at = '0;
               end
               oc             = s1_side_ff && at < lfdc_pkg::EARLY_MAX_TICKS;
               ahead_ticks_in = at;
               edge_l_in      = edge_l_new;
               edge_r_in      = edge_r_new;
               if (wneg) begin
                  left_spd  = slowed_clamped;
                  right_spd = $signed(CW'(cruise_speed_ff));
               end else begin
                  left_spd  = $signed(CW'(cruise_speed_ff));
                  right_spd = slowed_clamped;
               end
            end
            lfdc_pkg::ACT_APPROACH: begin
               edge_l_in = edge_l_new;
               edge_r_in = edge_r_new;
               intr_in   = 1'b0;
               if (s1_side_ff) begin
                  intr_in = 1'b1;
                  fin     = 1'b1;
               end else if (wneg) begin
                  left_spd  = slowed;
                  right_spd = $signed(CW'(approach_speed_ff));
               end else begin
                  left_spd  = $signed(CW'(approach_speed_ff));
                  right_spd = slowed;
               end
            end
            lfdc_pkg::ACT_LEFT, lfdc_pkg::ACT_RIGHT: begin
               intr_in = 1'b0;
               if (turn_ticks < fast_turn_ticks_ff) begin
                  turn_mag = $signed(CW'(fast_turn_speed_ff));
                  if (is_left_turn) begin
                     lturn_in = lturn_ff + TW'(1);
                  end else begin
                     rturn_in = rturn_ff + TW'(1);
                  end
               end else if (s1_side_ff) begin
                  action_in = lfdc_pkg::ACT_STOP;
                  intr_in   = 1'b1;
                  fin       = 1'b1;
                  if (is_left_turn) begin
                     lturn_in = '0;
                  end else begin
                     rturn_in = '0;
                  end
               end else begin
                  turn_mag = $signed(CW'(slow_turn_speed_ff));
               end
               if (is_left_turn) begin
                  left_spd  = -turn_mag;
                  right_spd = turn_mag;
               end else begin
                  left_spd  = turn_mag;
                  right_spd = -turn_mag;
               end
            end
            lfdc_pkg::ACT_BACK: begin
               rev = 1'b1;
               fin = 1'b1;
            end
            default: begin
               intr_in = 1'b1;
               fin     = 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !rsp_tready);
   assign rsp_user_in  = !s1_type_ff;
   assign rsp_data_in  = {6'b0, action_in, acc, rev, fin, oc, hc,
                          right_spd[OW-1:0], left_spd[OW-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cruise_speed_ff     <= lfdc_pkg::RST_CRUISE_SPEED;
         cruise_min_speed_ff <= lfdc_pkg::RST_CRUISE_MIN_SPEED;
         cruise_gain_ff      <= lfdc_pkg::RST_CRUISE_GAIN;
         approach_speed_ff   <= lfdc_pkg::RST_APPROACH_SPEED;
         approach_gain_ff    <= lfdc_pkg::RST_APPROACH_GAIN;
         fast_turn_speed_ff  <= lfdc_pkg::RST_FAST_TURN_SPEED;
         slow_turn_speed_ff  <= lfdc_pkg::RST_SLOW_TURN_SPEED;
         fast_turn_ticks_ff  <= lfdc_pkg::RST_FAST_TURN_TICKS;
      end else if (csr_we) begin
         case (csr_addr)
            lfdc_pkg::CSR_CRUISE_SPEED:     cruise_speed_ff     <= csr_wdata;
            lfdc_pkg::CSR_CRUISE_MIN_SPEED: cruise_min_speed_ff <= csr_wdata;
            lfdc_pkg::CSR_CRUISE_GAIN:      cruise_gain_ff      <= csr_wdata[GW-1:0];
            lfdc_pkg::CSR_APPROACH_SPEED:   approach_speed_ff   <= csr_wdata;
            lfdc_pkg::CSR_APPROACH_GAIN:    approach_gain_ff    <= csr_wdata[GW-1:0];
            lfdc_pkg::CSR_FAST_TURN_SPEED:  fast_turn_speed_ff  <= csr_wdata;
            lfdc_pkg::CSR_SLOW_TURN_SPEED:  slow_turn_speed_ff  <= csr_wdata;
            lfdc_pkg::CSR_FAST_TURN_TICKS:  fast_turn_ticks_ff  <= csr_wdata[TW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         action_ff      <= lfdc_pkg::ACT_AHEAD;
         intr_ff        <= 1'b1;
         ahead_ticks_ff <= '0;
         lturn_ff       <= '0;
         rturn_ff       <= '0;
         edge_l_ff      <= lfdc_pkg::RST_EDGE_LEFT;
         edge_r_ff      <= lfdc_pkg::RST_EDGE_RIGHT;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         action_ff      <= action_in;
         intr_ff        <= intr_in;
         ahead_ticks_ff <= ahead_ticks_in;
         lturn_ff       <= lturn_in;
         rturn_ff       <= rturn_in;
         edge_l_ff      <= edge_l_in;
         edge_r_ff      <= edge_r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_type_ff  <= req_tuser;
         s1_front_ff <= req_tdata[FW-1:0];
         s1_side_ff  <= req_tdata[FW] || req_tdata[FW+1];
         s1_code_ff  <= req_tdata[FW+2+:AW];
      end
      if (fire) begin
         rsp_user_ff <= rsp_user_in;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   // only turns and approach hold off commands
   a_intr_actions: assert property (@(posedge clock) disable iff (reset)
      !intr_ff |-> (action_ff == lfdc_pkg::ACT_LEFT || action_ff == lfdc_pkg::ACT_RIGHT
                    || action_ff == lfdc_pkg::ACT_APPROACH))
      else $error("command blocked outside turn or approach");

   a_cross_clears: assert property (@(posedge clock) disable iff (reset)
      (tick && action_ff == lfdc_pkg::ACT_AHEAD && hc) |=> ahead_ticks_ff == '0)
      else $error("ahead tick count not cleared on crossing");

   a_turn_done_stop: assert property (@(posedge clock) disable iff (reset)
      (tick && (action_ff == lfdc_pkg::ACT_LEFT || action_ff == lfdc_pkg::ACT_RIGHT) && fin)
      |=> action_ff == lfdc_pkg::ACT_STOP && intr_ff)
      else $error("finished turn did not fall back to stop");

   a_cmd_no_drive: assert property (@(posedge clock) disable iff (reset)
      (fire && s1_type_ff) |=> rsp_tvalid && !rsp_tuser && rsp_tdata[41:0] == '0)
      else $error("command transfer drove wheel speeds");

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line-follow drive controller. Commands and
// control ticks are streamed in bursts with random gaps, results are taken
// under a shifting back-pressure pattern and compared field by field against
// an in-bench model of the action sequencer and the steering arithmetic.
// Register settings are swept between phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [lfdc_pkg::ACT_W-1:0] ACT_SPARE6 = 3'd6;
   localparam logic [lfdc_pkg::ACT_W-1:0] ACT_SPARE7 = 3'd7;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic                          is_command;
      logic [lfdc_pkg::FRONT_W-1:0]  front;
      logic                          side_l;
      logic                          side_r;
      logic [lfdc_pkg::ACT_W-1:0]    code;
   } req_item_type;

   typedef struct packed {
      logic                            drive_valid;
      logic [lfdc_pkg::OUT_SPD_W-1:0]  left_speed;
      logic [lfdc_pkg::OUT_SPD_W-1:0]  right_speed;
      logic                            hc_ev;
      logic                            oc_ev;
      logic                            finish_ev;
      logic                            reverse_ev;
      logic                            accepted;
      logic [lfdc_pkg::ACT_W-1:0]      action_now;
   } drive_result_type;

   typedef struct packed {
      logic [lfdc_pkg::CSR_DW-1:0] cruise_speed;
      logic [lfdc_pkg::CSR_DW-1:0] cruise_min;
      logic [lfdc_pkg::CSR_DW-1:0] cruise_gain;
      logic [lfdc_pkg::CSR_DW-1:0] approach_speed;
      logic [lfdc_pkg::CSR_DW-1:0] approach_gain;
      logic [lfdc_pkg::CSR_DW-1:0] fast_speed;
      logic [lfdc_pkg::CSR_DW-1:0] slow_speed;
      logic [lfdc_pkg::CSR_DW-1:0] fast_ticks;
   } drive_cfg_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [lfdc_pkg::REQ_DW-1:0]  req_tdata = '0;
   logic                         req_tuser = 1'b0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [lfdc_pkg::RSP_DW-1:0]  rsp_tdata;
   logic                         rsp_tuser;
   logic                         csr_we = 1'b0;
   logic [lfdc_pkg::CSR_AW-1:0]  csr_addr = '0;
   logic [lfdc_pkg::CSR_DW-1:0]  csr_wdata = '0;

   line_follow_drive_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // model state and register copies
   int          sh_cruise_speed, sh_cruise_min, sh_cruise_gain;
   int          sh_approach_speed, sh_approach_gain;
   int          sh_fast_speed, sh_slow_speed, sh_fast_ticks;
   logic [lfdc_pkg::ACT_W-1:0] cur_action = lfdc_pkg::ACT_AHEAD;
   bit          intr_allowed = 1'b1;
   int          ahead_cnt = 0, lturn_cnt = 0, rturn_cnt = 0;
   int          edge_l = int'(lfdc_pkg::RST_EDGE_LEFT);
   int          edge_r = int'(lfdc_pkg::RST_EDGE_RIGHT);

   drive_result_type pending_drive_q [$];

   int  items_sent = 0, results_checked = 0, mismatch_count = 0, settings_loaded = 0;
   int  burst_left = 1;
   bit  sender_gaps_on = 1'b1;
   logic hold_rsp = 1'b0;

   int         rx_mode = 0, rx_mode_left = 0;
   logic [7:0] rx_mask = 8'h01;

   // ---------------------------------------------------------------- model
   function automatic int line_weight_at(input int pos);
      case (pos)
         0: return -1000;
         1: return -300;
         2: return -150;
         3: return -60;
         4: return -50;
         5: return 0;
         6: return 50;
         7: return 60;
         8: return 100;
         9: return 300;
         default: return 1000;
      endcase
   endfunction

   // edges persist when the bar shows none
   function automatic int steer_weight(input logic [lfdc_pkg::FRONT_W-1:0] s);
      int pos;
      for (int i = 1; i < 10; i++) begin
         if (s[i] && !s[i-1]) edge_l = i;
         if (s[i] && !s[i+1]) edge_r = i;
      end
      pos = (edge_r - edge_l) / 2 + edge_l;
      if (pos < 0) pos = 0;
      if (pos > 10) pos = 10;
      return line_weight_at(pos);
   endfunction

   function automatic bit is_head_cross(input logic [lfdc_pkg::FRONT_W-1:0] s);
      return ($countones(s) >= int'(lfdc_pkg::CROSS_MIN_COUNT) && s[2:0] == 3'b111) ||
             (s[10:8] == 3'b111);
   endfunction

   function automatic drive_result_type predict_drive(input req_item_type it);
      drive_result_type r;
      bit side, done, left_dir;
      int w, u, mag, cnt;
      r = '0;
      side = it.side_l | it.side_r;
      if (it.is_command) begin
         if (intr_allowed) begin
            cur_action = it.code;
            r.accepted = 1'b1;
         end
      end else begin
         r.drive_valid = 1'b1;
         case (cur_action)
            lfdc_pkg::ACT_AHEAD: begin
               if (ahead_cnt < int'(lfdc_pkg::AHEAD_TICKS_MAX)) ahead_cnt++;
               intr_allowed = 1'b1;
               if (is_head_cross(it.front) &&
                   ahead_cnt > int'(lfdc_pkg::CROSS_MIN_TICKS)) begin
                  r.hc_ev = 1'b1;
                  ahead_cnt = 0;
               end
               if (side && ahead_cnt < int'(lfdc_pkg::EARLY_MAX_TICKS)) r.oc_ev = 1'b1;
               w = steer_weight(it.front);
               if (w < 0) begin
                  u = sh_cruise_speed + w * sh_cruise_gain;
                  if (u < sh_cruise_min) u = sh_cruise_min;
                  r.left_speed  = 21'(u);
                  r.right_speed = 21'(sh_cruise_speed);
               end else begin
                  u = sh_cruise_speed - w * sh_cruise_gain;
                  if (u < sh_cruise_min) u = sh_cruise_min;
                  r.left_speed  = 21'(sh_cruise_speed);
                  r.right_speed = 21'(u);
               end
            end
            lfdc_pkg::ACT_APPROACH: begin
               w = steer_weight(it.front);
               intr_allowed = 1'b0;
               if (side) begin
                  intr_allowed = 1'b1;
                  r.finish_ev = 1'b1;
               end else if (w < 0) begin
                  r.left_speed  = 21'(sh_approach_speed + w * sh_approach_gain);
                  r.right_speed = 21'(sh_approach_speed);
               end else begin
                  r.left_speed  = 21'(sh_approach_speed);
                  r.right_speed = 21'(sh_approach_speed - w * sh_approach_gain);
               end
            end
            lfdc_pkg::ACT_LEFT, lfdc_pkg::ACT_RIGHT: begin
               left_dir = (cur_action == lfdc_pkg::ACT_LEFT);
               cnt = left_dir ? lturn_cnt : rturn_cnt;
               intr_allowed = 1'b0;
               done = 1'b0;
               if (cnt < sh_fast_ticks) begin
                  mag = sh_fast_speed;
                  cnt++;
               end else if (side) begin
                  mag = 0;
                  done = 1'b1;
                  cnt = 0;
               end else begin
                  mag = sh_slow_speed;
               end
               if (left_dir) lturn_cnt = cnt;
               else rturn_cnt = cnt;
               if (done) begin
                  r.finish_ev = 1'b1;
                  cur_action = lfdc_pkg::ACT_STOP;
                  intr_allowed = 1'b1;
               end else if (left_dir) begin
                  r.left_speed  = 21'(-mag);
                  r.right_speed = 21'(mag);
               end else begin
                  r.left_speed  = 21'(mag);
                  r.right_speed = 21'(-mag);
               end
            end
            lfdc_pkg::ACT_BACK: begin
               r.reverse_ev = 1'b1;
               r.finish_ev  = 1'b1;
            end
            default: begin
               intr_allowed = 1'b1;
               r.finish_ev = 1'b1;
            end
         endcase
      end
      r.action_now = cur_action;
      return r;
   endfunction

   // ---------------------------------------------------------------- driving
   task automatic drive_item(input req_item_type it);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= it.is_command;
      req_tdata  <= {it.code, it.side_r, it.side_l, it.front};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_drive_q.push_back(predict_drive(it));
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (sender_gaps_on && gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_drive_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [lfdc_pkg::CSR_AW-1:0] addr,
                            input logic [lfdc_pkg::CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      case (addr)
         lfdc_pkg::CSR_CRUISE_SPEED:     sh_cruise_speed   = int'(data);
         lfdc_pkg::CSR_CRUISE_MIN_SPEED: sh_cruise_min     = int'(data);
         lfdc_pkg::CSR_CRUISE_GAIN:      sh_cruise_gain    = int'(data[lfdc_pkg::GAIN_W-1:0]);
         lfdc_pkg::CSR_APPROACH_SPEED:   sh_approach_speed = int'(data);
         lfdc_pkg::CSR_APPROACH_GAIN:    sh_approach_gain  = int'(data[lfdc_pkg::GAIN_W-1:0]);
         lfdc_pkg::CSR_FAST_TURN_SPEED:  sh_fast_speed     = int'(data);
         lfdc_pkg::CSR_SLOW_TURN_SPEED:  sh_slow_speed     = int'(data);
         default:                        sh_fast_ticks     = int'(data[lfdc_pkg::TICK_W-1:0]);
      endcase
   endtask

   // block must be idle when called
   task automatic load_settings(input drive_cfg_type c);
      csr_write(lfdc_pkg::CSR_CRUISE_SPEED,     c.cruise_speed);
      csr_write(lfdc_pkg::CSR_CRUISE_MIN_SPEED, c.cruise_min);
      csr_write(lfdc_pkg::CSR_CRUISE_GAIN,      c.cruise_gain);
      csr_write(lfdc_pkg::CSR_APPROACH_SPEED,   c.approach_speed);
      csr_write(lfdc_pkg::CSR_APPROACH_GAIN,    c.approach_gain);
      csr_write(lfdc_pkg::CSR_FAST_TURN_SPEED,  c.fast_speed);
      csr_write(lfdc_pkg::CSR_SLOW_TURN_SPEED,  c.slow_speed);
      csr_write(lfdc_pkg::CSR_FAST_TURN_TICKS,  c.fast_ticks);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_loaded++;
   endtask

   function automatic drive_cfg_type default_settings();
      drive_cfg_type c;
      c.cruise_speed   = lfdc_pkg::CSR_DW'(lfdc_pkg::RST_CRUISE_SPEED);
      c.cruise_min     = lfdc_pkg::CSR_DW'(lfdc_pkg::RST_CRUISE_MIN_SPEED);
      c.cruise_gain    = lfdc_pkg::CSR_DW'(lfdc_pkg::RST_CRUISE_GAIN);
      c.approach_speed = lfdc_pkg::CSR_DW'(lfdc_pkg::RST_APPROACH_SPEED);
      c.approach_gain  = lfdc_pkg::CSR_DW'(lfdc_pkg::RST_APPROACH_GAIN);
      c.fast_speed     = lfdc_pkg::CSR_DW'(lfdc_pkg::RST_FAST_TURN_SPEED);
      c.slow_speed     = lfdc_pkg::CSR_DW'(lfdc_pkg::RST_SLOW_TURN_SPEED);
      c.fast_ticks     = lfdc_pkg::CSR_DW'(lfdc_pkg::RST_FAST_TURN_TICKS);
      return c;
   endfunction

   function automatic drive_cfg_type random_settings();
      drive_cfg_type c;
      c.cruise_speed   = lfdc_pkg::CSR_DW'($urandom);
      c.cruise_min     = lfdc_pkg::CSR_DW'($urandom);
      c.cruise_gain    = lfdc_pkg::CSR_DW'($urandom);
      c.approach_speed = lfdc_pkg::CSR_DW'($urandom);
      c.approach_gain  = lfdc_pkg::CSR_DW'($urandom);
      c.fast_speed     = lfdc_pkg::CSR_DW'($urandom);
      c.slow_speed     = lfdc_pkg::CSR_DW'($urandom);
      // short fast phase; upper bits random to exercise the register width
      c.fast_ticks     = {6'($urandom), 8'($urandom_range(0, 6))};
      return c;
   endfunction

   function automatic logic [lfdc_pkg::FRONT_W-1:0] pick_front();
      int w, p;
      logic [lfdc_pkg::FRONT_W-1:0] s;
      case ($urandom_range(0, 9))
         0: s = '0;
         1: s = '1;
         2: s = 11'h007 | 11'($urandom);
         3: s = 11'h700 | 11'($urandom);
         4: s = 11'($urandom);
         default: begin
            w = $urandom_range(1, 3);
            p = $urandom_range(0, 10);
            s = (11'h007 >> (3 - w)) << p;
         end
      endcase
      return s;
   endfunction

   function automatic req_item_type tick(input logic [lfdc_pkg::FRONT_W-1:0] front,
                                         input logic sl, input logic sr);
      req_item_type it;
      it.is_command = 1'b0;
      it.front      = front;
      it.side_l     = sl;
      it.side_r     = sr;
      it.code       = 3'($urandom);
      return it;
   endfunction

   function automatic req_item_type cmd(input logic [lfdc_pkg::ACT_W-1:0] code);
      req_item_type it;
      it.is_command = 1'b1;
      it.front      = 11'($urandom);
      it.side_l     = 1'($urandom);
      it.side_r     = 1'($urandom);
      it.code       = code;
      return it;
   endfunction

   function automatic req_item_type random_tick();
      return tick(pick_front(), $urandom_range(0, 99) < 12, $urandom_range(0, 99) < 12);
   endfunction

   // mostly a command followed by a run of ticks, the rest loose noise
   task automatic run_scenarios(input int n_items);
      int sent, len;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 9) < 8) begin
            drive_item(cmd(3'($urandom)));
            len = $urandom_range(3, 30);
            repeat (len) drive_item(random_tick());
            sent += len + 1;
         end else begin
            len = $urandom_range(1, 8);
            repeat (len) begin
               if ($urandom_range(0, 99) < 40) drive_item(cmd(3'($urandom)));
               else drive_item(random_tick());
            end
            sent += len;
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left <= 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(32, 256);
            rx_mask      = 8'($urandom) | 8'h01;
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: begin
               rx_mask = {rx_mask[6:0], rx_mask[7]};
               rsp_tready <= rx_mask[0];
            end
         endcase
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result %0d, %s: expected %0h, got %0h",
                     results_checked, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_drive_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("result transfer with nothing outstanding: tdata %0h", rsp_tdata);
         end else begin
            want = pending_drive_q.pop_front();
            check_field("drive_valid", 32'(want.drive_valid), 32'(rsp_tuser));
            check_field("left_speed", 32'(want.left_speed), 32'(rsp_tdata[20:0]));
            check_field("right_speed", 32'(want.right_speed), 32'(rsp_tdata[41:21]));
            check_field("head_cross_event", 32'(want.hc_ev), 32'(rsp_tdata[42]));
            check_field("on_cross_event", 32'(want.oc_ev), 32'(rsp_tdata[43]));
            check_field("finish_event", 32'(want.finish_ev), 32'(rsp_tdata[44]));
            check_field("reverse_direction", 32'(want.reverse_ev), 32'(rsp_tdata[45]));
            check_field("command_accepted", 32'(want.accepted), 32'(rsp_tdata[46]));
            check_field("action_now", 32'(want.action_now), 32'(rsp_tdata[49:47]));
            results_checked++;
         end
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_directed_ahead();
      drive_item(tick(11'h000, 1'b0, 1'b0));   // no edge, centre weight
      drive_item(tick(11'h7FF, 1'b0, 1'b0));   // full bar, too early for a crossing
      drive_item(tick(11'h001, 1'b0, 1'b0));
      drive_item(tick(11'h400, 1'b0, 1'b0));
      drive_item(tick(11'h002, 1'b0, 1'b0));   // hard left, clamp
      drive_item(tick(11'h200, 1'b0, 1'b0));   // hard right, clamp
      drive_item(tick(11'h020, 1'b1, 1'b1));   // early side crossing
      drive_item(tick(11'h700, 1'b0, 1'b0));   // head crossing
      drive_item(tick(11'h0FF, 1'b0, 1'b0));   // crossing again too soon
   endtask

   task automatic test_directed_actions();
      drive_cfg_type c;
      wait_drained();
      c = default_settings();
      c.fast_ticks = 14'd2;
      load_settings(c);
      drive_item(cmd(lfdc_pkg::ACT_LEFT));
      drive_item(tick(11'h020, 1'b1, 1'b0));   // fast phase ignores the side sensors
      drive_item(cmd(lfdc_pkg::ACT_STOP));     // refused mid-turn
      drive_item(tick(11'h020, 1'b0, 1'b0));
      drive_item(tick(11'h020, 1'b0, 1'b0));   // slow phase
      drive_item(tick(11'h020, 1'b1, 1'b0));   // turn done
      drive_item(tick(11'h020, 1'b0, 1'b0));   // stop
      drive_item(cmd(lfdc_pkg::ACT_RIGHT));
      drive_item(tick(11'h010, 1'b1, 1'b1));
      drive_item(tick(11'h010, 1'b0, 1'b0));
      drive_item(tick(11'h010, 1'b0, 1'b1));
      drive_item(cmd(lfdc_pkg::ACT_BACK));
      drive_item(tick(11'h3F0, 1'b0, 1'b0));
      drive_item(cmd(ACT_SPARE6));
      drive_item(tick(11'h001, 1'b0, 1'b0));
      drive_item(cmd(ACT_SPARE7));
      drive_item(tick(11'h001, 1'b0, 1'b0));
      drive_item(cmd(lfdc_pkg::ACT_APPROACH));
      drive_item(tick(11'h004, 1'b0, 1'b0));   // approach, left wheel negative
      drive_item(cmd(lfdc_pkg::ACT_AHEAD));    // refused during approach
      drive_item(tick(11'h100, 1'b1, 1'b0));   // approach done
      drive_item(cmd(lfdc_pkg::ACT_AHEAD));
      drive_item(tick(11'h060, 1'b0, 1'b0));
   endtask

   task automatic test_settings_sweep();
      drive_cfg_type c;
      wait_drained();
      load_settings(default_settings());
      run_scenarios(130);
      wait_drained();
      c = '1;
      load_settings(c);
      run_scenarios(130);
      wait_drained();
      c = '0;
      load_settings(c);
      run_scenarios(130);
      repeat (3) begin
         wait_drained();
         load_settings(random_settings());
         run_scenarios(130);
      end
   endtask

   task automatic test_output_stall();
      sender_gaps_on = 1'b0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         run_scenarios(60);
      join
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_sender_pause();
      run_scenarios(30);
      wait_drained();
      run_scenarios(30);
   endtask

   task automatic test_random_noise();
      repeat (100) begin
         if ($urandom_range(0, 99) < 40) drive_item(cmd(3'($urandom)));
         else drive_item(random_tick());
      end
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      int waited;
      sh_cruise_speed   = int'(lfdc_pkg::RST_CRUISE_SPEED);
      sh_cruise_min     = int'(lfdc_pkg::RST_CRUISE_MIN_SPEED);
      sh_cruise_gain    = int'(lfdc_pkg::RST_CRUISE_GAIN);
      sh_approach_speed = int'(lfdc_pkg::RST_APPROACH_SPEED);
      sh_approach_gain  = int'(lfdc_pkg::RST_APPROACH_GAIN);
      sh_fast_speed     = int'(lfdc_pkg::RST_FAST_TURN_SPEED);
      sh_slow_speed     = int'(lfdc_pkg::RST_SLOW_TURN_SPEED);
      sh_fast_ticks     = int'(lfdc_pkg::RST_FAST_TURN_TICKS);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ahead();
      test_directed_actions();
      test_settings_sweep();
      test_output_stall();
      test_sender_pause();
      test_random_noise();

      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_drive_q.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pending_drive_q.size() != 0) begin
         mismatch_count += pending_drive_q.size();
         $display("%0d results never arrived", pending_drive_q.size());
      end
      $display("%0d requests sent, %0d results checked, %0d register settings loaded",
               items_sent, results_checked, settings_loaded);
      $display("covered all actions, turn phases, crossings and output stall; %0d errors",
               mismatch_count);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #8000000;
      $display("timeout with %0d results outstanding", pending_drive_q.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
